FILE: src/cpl_pkg.sv
package cpl_pkg;

    localparam int DATA_W = 32;
    localparam int LEN_W = 16;
    localparam int ID_W = 10;
    localparam int ENTRY_IDX_W = 10;
    localparam int COUNT_CFG_W = 11;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_REF_LENGTH   = 1'b0,
        REG_CONTIG_COUNT = 1'b1
    } cfg_reg_t;

endpackage

FILE: src/contig_position_lookup.sv
// Channel    Direction  Handshake                    Payload
// command    in         start high while busy low     mode, entry_index, entry_offset,
//                                                     packed_position, alignment_length
// result     out        result_valid, one cycle      contig_id, contig_position,
//                                                     spans_two, out_of_range
// config     in         cfg_write, no wait           cfg_index, cfg_data
//
// A table write does not set busy; the next command may follow at once.
// A query holds busy from its transfer until the last-base search leaves
// the row of NC = clog2(MAX_CONTIGS + 1) search cells of two stages each.
// The last-base search enters the row in the cycle after the first-base search
// and follows it through the cells, sharing two single-read copies of the table.
// Reset clears control and the reference length and sets the contig count to one;
// the table is undefined until written. The receiver cannot stall; result_valid is high for exactly one cycle.
module contig_position_lookup #(
    parameter int MAX_CONTIGS = 1024
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                mode,
    input  logic [cpl_pkg::ENTRY_IDX_W-1:0]     entry_index,
    input  logic [cpl_pkg::DATA_W-1:0]          entry_offset,
    input  logic [cpl_pkg::DATA_W-1:0]          packed_position,
    input  logic [cpl_pkg::LEN_W-1:0]           alignment_length,
    output logic                                result_valid,
    output logic [cpl_pkg::ID_W-1:0]            contig_id,
    output logic [cpl_pkg::DATA_W-1:0]          contig_position,
    output logic                                spans_two,
    output logic                                out_of_range,
    input  logic                                cfg_write,
    input  logic [cpl_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [cpl_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int CNT_W = $clog2(MAX_CONTIGS + 1);
    localparam int ADDR_W = (MAX_CONTIGS > 1) ? $clog2(MAX_CONTIGS) : 1;
    localparam int NC = CNT_W;
    localparam int TOK_W = 3 * CNT_W + 2 * cpl_pkg::DATA_W + 4;

    typedef struct packed {
        logic                          valid;
        logic                          second;
        logic                          done;
        logic [CNT_W-1:0]              lo;
        logic [CNT_W-1:0]              hi;
        logic [CNT_W-1:0]              mid;
        logic [cpl_pkg::DATA_W:0]      pos;
        logic [cpl_pkg::DATA_W-1:0]    base;
    } tok_t;

    logic [cpl_pkg::DATA_W-1:0]       ref_length_reg;
    logic [cpl_pkg::COUNT_CFG_W-1:0]  count_reg;
    logic                             busy_reg;
    logic                             launch_b_reg;
    logic                             result_valid_reg;
    logic [cpl_pkg::DATA_W-1:0]       first_reg;
    logic [cpl_pkg::DATA_W:0]         last_reg;
    logic                             oor_reg;
    logic [CNT_W-1:0]                 a_mid_reg;
    logic [cpl_pkg::DATA_W-1:0]       a_base_reg;
    logic [cpl_pkg::ID_W-1:0]         contig_id_reg;
    logic [cpl_pkg::DATA_W-1:0]       contig_position_reg;
    logic                             spans_two_reg;
    logic                             out_of_range_reg;

    logic                             accept;
    logic                             query_acc;
    logic                             write_acc;
    logic                             ram_we;
    logic [cpl_pkg::LEN_W-1:0]        len_eff;
    logic [cpl_pkg::DATA_W:0]         last_pos;
    logic [CNT_W-1:0]                 eff_count;
    tok_t                             launch_tok;
    tok_t                             exit_tok;
    logic [ADDR_W-1:0]                ram_raddr_a;
    logic [ADDR_W-1:0]                ram_raddr_b;
    logic [cpl_pkg::DATA_W-1:0]       rd_a;
    logic [cpl_pkg::DATA_W-1:0]       rd_b;

    logic [TOK_W-1:0]                 tok_chain [0:NC];
    logic [ADDR_W-1:0]                addr_a_chain [0:NC];
    logic [ADDR_W-1:0]                addr_b_chain [0:NC];

    assign accept = start && !busy_reg;
    assign query_acc = accept && mode;
    assign write_acc = accept && !mode;
    assign ram_we = write_acc && (32'(entry_index) < 32'(MAX_CONTIGS));

    assign len_eff = (alignment_length == '0) ? cpl_pkg::LEN_W'(1) : alignment_length;
    assign last_pos = {1'b0, packed_position} + 33'(len_eff) - 33'd1;

    always_comb
    begin
        if (count_reg == '0)
        begin
            eff_count = CNT_W'(1);
        end
        else if (32'(count_reg) > 32'(MAX_CONTIGS))
        begin
            eff_count = CNT_W'(MAX_CONTIGS);
        end
        else
        begin
            eff_count = CNT_W'(count_reg);
        end
    end

    always_comb
    begin
        launch_tok = '0;
        launch_tok.hi = eff_count;
        launch_tok.mid = eff_count >> 1;
        if (query_acc)
        begin
            launch_tok.valid = 1'b1;
            launch_tok.pos = {1'b0, packed_position};
        end
        else if (launch_b_reg)
        begin
            launch_tok.valid = 1'b1;
            launch_tok.second = 1'b1;
            launch_tok.pos = last_reg;
        end
    end

    assign tok_chain[0] = launch_tok;
    assign addr_a_chain[0] = '0;
    assign addr_b_chain[0] = '0;

    for (genvar i = 0; i < NC; i++)
    begin : g_cell
        cpl_cell #(
            .CNT_W  (CNT_W),
            .ADDR_W (ADDR_W)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .count      (eff_count),
            .tok_in     (tok_chain[i]),
            .tok_out    (tok_chain[i+1]),
            .addr_a_in  (addr_a_chain[i]),
            .addr_b_in  (addr_b_chain[i]),
            .addr_a_out (addr_a_chain[i+1]),
            .addr_b_out (addr_b_chain[i+1]),
            .rd_a       (rd_a),
            .rd_b       (rd_b)
        );
    end

    assign ram_raddr_a = addr_a_chain[NC];
    assign ram_raddr_b = addr_b_chain[NC];
    assign exit_tok = tok_t'(tok_chain[NC]);

    // Two copies of the table give the probe entry and its successor in one read.
    cpl_ram #(
        .WIDTH (cpl_pkg::DATA_W),
        .DEPTH (MAX_CONTIGS)
    ) u_ram_a (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ADDR_W'(entry_index)),
        .wdata (entry_offset),
        .raddr (ram_raddr_a),
        .rdata (rd_a)
    );

    cpl_ram #(
        .WIDTH (cpl_pkg::DATA_W),
        .DEPTH (MAX_CONTIGS)
    ) u_ram_b (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ADDR_W'(entry_index)),
        .wdata (entry_offset),
        .raddr (ram_raddr_b),
        .rdata (rd_b)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_length_reg <= '0;
            count_reg <= cpl_pkg::COUNT_CFG_W'(1);
        end
        else if (cfg_write)
        begin
            unique case (cpl_pkg::cfg_reg_t'(cfg_index))
                cpl_pkg::REG_REF_LENGTH:
                begin
                    ref_length_reg <= cfg_data;
                end
                cpl_pkg::REG_CONTIG_COUNT:
                begin
                    count_reg <= cfg_data[cpl_pkg::COUNT_CFG_W-1:0];
                end
                default:
                begin
                    ref_length_reg <= ref_length_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            launch_b_reg <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            launch_b_reg <= query_acc;
            result_valid_reg <= exit_tok.valid && exit_tok.second;
            if (query_acc)
            begin
                busy_reg <= 1'b1;
            end
            else if (exit_tok.valid && exit_tok.second)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (query_acc)
        begin
            first_reg <= packed_position;
            last_reg <= last_pos;
            oor_reg <= last_pos >= {1'b0, ref_length_reg};
        end
        if (exit_tok.valid && !exit_tok.second)
        begin
            a_mid_reg <= exit_tok.mid;
            a_base_reg <= exit_tok.base;
        end
        if (exit_tok.valid && exit_tok.second)
        begin
            contig_id_reg <= '0;
            contig_position_reg <= '0;
            spans_two_reg <= 1'b0;
            out_of_range_reg <= oor_reg;
            if (!oor_reg)
            begin
                if (a_mid_reg != exit_tok.mid)
                begin
                    spans_two_reg <= 1'b1;
                end
                else
                begin
                    contig_id_reg <= cpl_pkg::ID_W'(a_mid_reg);
                    contig_position_reg <= first_reg - a_base_reg;
                end
            end
        end
    end

    assign busy = busy_reg;
    assign result_valid = result_valid_reg;
    assign contig_id = contig_id_reg;
    assign contig_position = contig_position_reg;
    assign spans_two = spans_two_reg;
    assign out_of_range = out_of_range_reg;

    a_query_launches_second: assert property (@(posedge clk) disable iff (!rst_n)
        query_acc |=> busy_reg && launch_b_reg)
        else $error("query transfer did not start the second search");

    a_result_frees_block: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> !busy_reg)
        else $error("result shown while the block is still busy");

    a_second_exit_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        exit_tok.valid && exit_tok.second |-> busy_reg && !launch_b_reg)
        else $error("search token left the row outside a query");

    a_flag_clears_payload: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && out_of_range_reg |->
            !spans_two_reg && (contig_id_reg == '0) && (contig_position_reg == '0))
        else $error("out-of-range result carries a payload");

endmodule

FILE: src/cpl_ram.sv
module cpl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/cpl_cell.sv
module cpl_cell #(
    parameter int CNT_W = 11,
    parameter int ADDR_W = 10,
    localparam int TOK_W = 3 * CNT_W + 2 * cpl_pkg::DATA_W + 4
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [CNT_W-1:0]            count,
    input  logic [TOK_W-1:0]            tok_in,
    output logic [TOK_W-1:0]            tok_out,
    input  logic [ADDR_W-1:0]           addr_a_in,
    input  logic [ADDR_W-1:0]           addr_b_in,
    output logic [ADDR_W-1:0]           addr_a_out,
    output logic [ADDR_W-1:0]           addr_b_out,
    input  logic [cpl_pkg::DATA_W-1:0]  rd_a,
    input  logic [cpl_pkg::DATA_W-1:0]  rd_b
);

    typedef struct packed {
        logic                          valid;
        logic                          second;
        logic                          done;
        logic [CNT_W-1:0]              lo;
        logic [CNT_W-1:0]              hi;
        logic [CNT_W-1:0]              mid;
        logic [cpl_pkg::DATA_W:0]      pos;
        logic [cpl_pkg::DATA_W-1:0]    base;
    } tok_t;

    tok_t             s0_reg;
    tok_t             s1_reg;
    tok_t             s0_next;
    tok_t             s1_next;
    logic [CNT_W-1:0] mid_inc;
    logic [CNT_W:0]   mid_sum;
    logic             live;

    assign s0_next = tok_t'(tok_in);
    assign mid_inc = s0_reg.mid + CNT_W'(1);

    // Only one token sits in an address stage at a time, so the read
    // addresses of all cells merge by OR along the row.
    assign addr_a_out = addr_a_in | (s0_reg.valid ? s0_reg.mid[ADDR_W-1:0] : '0);
    assign addr_b_out = addr_b_in | (s0_reg.valid ? mid_inc[ADDR_W-1:0] : '0);

    assign live = !s1_reg.done && (s1_reg.lo < s1_reg.hi);

    always_comb
    begin
        s1_next = s1_reg;
        mid_sum = '0;
        if (live)
        begin
            s1_next.base = rd_a;
            if ({1'b0, rd_a} <= s1_reg.pos)
            begin
                if ((s1_reg.mid == count - CNT_W'(1)) || (s1_reg.pos < {1'b0, rd_b}))
                begin
                    s1_next.done = 1'b1;
                end
                else
                begin
                    s1_next.lo = s1_reg.mid + CNT_W'(1);
                end
            end
            else
            begin
                s1_next.hi = s1_reg.mid;
            end
            mid_sum = {1'b0, s1_next.lo} + {1'b0, s1_next.hi};
            if (!s1_next.done && (s1_next.lo < s1_next.hi))
            begin
                s1_next.mid = mid_sum[CNT_W:1];
            end
        end
    end

    assign tok_out = s1_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_reg <= '0;
            s1_reg <= '0;
        end
        else
        begin
            s0_reg <= s0_next;
            s1_reg <= s0_reg;
        end
    end

    a_mid_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        s1_reg.valid && live |-> (s1_reg.mid >= s1_reg.lo) && (s1_reg.mid < s1_reg.hi))
        else $error("probe index outside the search window");

    a_token_order: assert property (@(posedge clk) disable iff (!rst_n)
        s0_reg.valid && s1_reg.valid |-> s0_reg.second != s1_reg.second)
        else $error("two tokens of the same kind in one cell");

endmodule
